@@ hw/rtl/count_min_sketch_seed_param_core_macros.svh @@
// Assertion macros shared by the sketch RTL.
`ifndef COUNT_MIN_SKETCH_SEED_PARAM_CORE_MACROS_SVH
`define COUNT_MIN_SKETCH_SEED_PARAM_CORE_MACROS_SVH

// Property that must hold whenever the block is out of reset.
`define CMS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define CMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/cms_pkg.sv @@
// ---------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the count-min sketch seed block.
// ---------------------------------------------------------------------------
`default_nettype none
package cms_pkg;

  localparam int unsigned ROWS = 4;
  localparam int unsigned ROW_BITS = 2;
  localparam int unsigned WORD_BITS = 32;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_MOD    = 9'b000000100,
    ST_READ   = 9'b000001000,
    ST_UPD    = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_REM    = 9'b001000000,
    ST_FIN    = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input item
    logic mod_start;  // start hash mod width for current row
    logic mem_read;   // issue read of current row index
    logic mem_write;  // write incremented counter, fold into min
    logic div_start;  // start min / divisor
    logic rem_start;  // start nonce % (quot+1)
    logic finish;     // form result registers
    logic clr_write;  // write zero at clear pointer
    logic [1:0] row;  // row being worked on
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_busy;
    logic clr_last;
  } stat_t;

  // Register indexes.
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_DIVISOR = 2'd1;
  localparam logic [1:0] REG_BLOWUP  = 2'd2;
  localparam logic [1:0] REG_THRESH  = 2'd3;

endpackage
`default_nettype wire

@@ hw/rtl/cms_divider.sv @@
// ---------------------------------------------------------------------------
// cms_divider
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module cms_divider #(
  parameter int unsigned N = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [N:0]   divisor,
  output logic              busy,
  output logic [N-1:0]      quotient,
  output logic [N:0]        remainder
);
  localparam int unsigned CW = $clog2(N + 1);

  logic [CW-1:0] cnt;
  logic [N:0]    rem;
  logic [N-1:0]  quo;
  logic [N:0]    dvs;
  logic [N+1:0]  trial;

  assign trial = {rem, quo[N-1]} - {1'b0, dvs};

  // Shift one dividend bit per cycle into the partial remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(N);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial[N+1]) begin
        rem <= {rem[N-1:0], quo[N-1]};
        quo <= {quo[N-2:0], 1'b0};
      end else begin
        rem <= trial[N:0];
        quo <= {quo[N-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule
`default_nettype wire

@@ hw/rtl/cms_datapath.sv @@
// ---------------------------------------------------------------------------
// cms_datapath
// Counter memory, modulo/divide unit, minimum and request counting.
// ---------------------------------------------------------------------------
`default_nettype none
`include "count_min_sketch_seed_param_core_macros.svh"
module cms_datapath #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cms_pkg::cmd_t          cmd,
  output cms_pkg::stat_t         stat,
  input  wire logic              mode,
  input  wire logic [31:0]       hash_word0,
  input  wire logic [31:0]       hash_word1,
  input  wire logic [31:0]       hash_word2,
  input  wire logic [31:0]       hash_word3,
  input  wire logic [31:0]       nonce,
  input  wire logic              batch_end,
  input  wire logic [12:0]       active_width,
  input  wire logic [31:0]       divisor,
  input  wire logic              blowup_disabled,
  input  wire logic [31:0]       solver_threshold,
  output logic [31:0]            seed_param,
  output logic [31:0]            min_count,
  output logic                   solver_request
);
  localparam int unsigned IW = $clog2(MAX_WIDTH);
  localparam int unsigned AW = IW + cms_pkg::ROW_BITS;
  // Each row spans a power-of-two slot so {row, index} addresses directly.
  localparam int unsigned DEPTH = cms_pkg::ROWS << IW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [31:0] hw_q [cms_pkg::ROWS];
  logic [31:0] nonce_q;
  logic        batch_q;
  logic        mode_q;
  logic [31:0] minv;
  logic [31:0] req_count;
  logic [IW-1:0] idx;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd;
  logic [AW-1:0] clr_ptr;
  logic [COUNT_BITS-1:0] inc;
  logic [31:0] inc32;
  logic [16:0] wid_eff;

  // Effective modulus: zero acts as one, clamp to the row size.
  always_comb begin
    if (active_width == 13'd0) wid_eff = 17'd1;
    else if ({4'd0, active_width} > 17'(MAX_WIDTH)) wid_eff = 17'(MAX_WIDTH);
    else wid_eff = {4'd0, active_width};
  end

  // Shared divider: row mod, minimum divide, nonce mod.
  logic        d_start;
  logic [31:0] d_dend;
  logic [32:0] d_dvs;
  logic [31:0] d_quo;
  logic [32:0] d_rem;
  logic        d_busy;

  always_comb begin
    d_start = cmd.mod_start | cmd.div_start | cmd.rem_start;
    d_dend  = hw_q[cmd.row];
    d_dvs   = {16'd0, wid_eff};
    if (cmd.div_start) begin
      d_dend = minv;
      d_dvs  = (divisor == 32'd0) ? 33'd1 : {1'b0, divisor};
    end else if (cmd.rem_start) begin
      d_dend = nonce_q;
      d_dvs  = {1'b0, d_quo} + 33'd1;
    end
  end

  cms_divider #(.N(32)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dend), .divisor(d_dvs),
    .busy(d_busy), .quotient(d_quo), .remainder(d_rem)
  );

  assign idx = d_rem[IW-1:0];
  assign inc = (rd == CMAX) ? rd : rd + 1'b1;
  assign inc32 = 32'(inc);

  // Counter memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.clr_write) mem[clr_ptr] <= '0;
    else if (cmd.mem_write) mem[{cmd.row, idx}] <= inc;
    if (cmd.mem_read) rd <= mem[{cmd.row, idx}];
  end

  // Clear pointer sweeps the whole memory.
  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clr_write) clr_ptr <= clr_ptr + 1'b1;
  end

  // Item capture, minimum and results.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_count <= '0;
    end else begin
      if (cmd.load) begin
        hw_q[0] <= hash_word0;
        hw_q[1] <= hash_word1;
        hw_q[2] <= hash_word2;
        hw_q[3] <= hash_word3;
        nonce_q <= nonce;
        batch_q <= batch_end;
        mode_q  <= mode;
        minv    <= '1;
        if (mode) req_count <= '0;
      end
      if (cmd.mem_write && inc32 < minv) minv <= inc32;
      if (cmd.finish) begin
        if (mode_q) begin
          seed_param     <= '0;
          min_count      <= '0;
          solver_request <= 1'b0;
        end else begin
          seed_param <= blowup_disabled ? 32'd1 : d_rem[31:0];
          min_count  <= minv;
          if (batch_q && ((req_count == '1 ? req_count : req_count + 1'b1)
                          >= solver_threshold)) begin
            solver_request <= 1'b1;
            req_count      <= '0;
          end else begin
            solver_request <= 1'b0;
            req_count      <= (req_count == '1) ? req_count : req_count + 1'b1;
          end
        end
      end
    end
  end

  assign stat.div_busy = d_busy;
  assign stat.clr_last = (clr_ptr == AW'(DEPTH - 1));

  `CMS_ASSERT(a_no_start_busy, clk, rst, !(d_start && d_busy), "divider restarted while busy")
  `CMS_ASSERT(a_one_op, clk, rst, !(cmd.mem_write && cmd.clr_write), "clear and update overlap")
  `CMS_ASSERT(a_min_monotone, clk, rst, (cmd.mem_write && !cmd.load) |=> (minv <= $past(minv)),
              "minimum grew")
endmodule
`default_nettype wire

@@ hw/rtl/cms_ctrl.sv @@
// ---------------------------------------------------------------------------
// cms_ctrl
// Sequencer: clear sweep, row updates, divide, modulo and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
`include "count_min_sketch_seed_param_core_macros.svh"
module cms_ctrl (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire logic      mode,
  input  cms_pkg::stat_t stat,
  output cms_pkg::cmd_t  cmd
);
  cms_pkg::state_t state, state_next;
  logic [1:0] row, row_next;
  logic       out_v_next;
  logic       started, started_next;

  // A held result does not block intake; the next item waits in FIN instead.
  assign in_ready = (state == cms_pkg::ST_IDLE);

  always_comb begin
    state_next   = state;
    row_next     = row;
    out_v_next   = out_valid;
    started_next = started;
    cmd          = '0;
    cmd.row      = row;
    if (out_valid && out_ready) out_v_next = 1'b0;
    unique case (state)
      cms_pkg::ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = started ? cms_pkg::ST_FIN : cms_pkg::ST_IDLE;
      end
      cms_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load     = 1'b1;
          row_next     = '0;
          started_next = 1'b1;
          state_next   = mode ? cms_pkg::ST_CLEAR : cms_pkg::ST_MOD;
        end
      end
      cms_pkg::ST_MOD: begin
        cmd.mod_start = 1'b1;
        state_next    = cms_pkg::ST_READ;
      end
      cms_pkg::ST_READ: begin
        if (!stat.div_busy) begin
          cmd.mem_read = 1'b1;
          state_next   = cms_pkg::ST_UPD;
        end
      end
      cms_pkg::ST_UPD: begin
        cmd.mem_write = 1'b1;
        row_next      = row + 1'b1;
        state_next    = (row == 2'd3) ? cms_pkg::ST_DIV : cms_pkg::ST_MOD;
      end
      cms_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = cms_pkg::ST_REM;
      end
      cms_pkg::ST_REM: begin
        if (!stat.div_busy) begin
          cmd.rem_start = 1'b1;
          state_next    = cms_pkg::ST_OUT;
        end
      end
      cms_pkg::ST_OUT: begin
        if (!stat.div_busy) state_next = cms_pkg::ST_FIN;
      end
      cms_pkg::ST_FIN: begin
        // wait until the result register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          out_v_next = 1'b1;
          state_next = cms_pkg::ST_IDLE;
        end
      end
      default: state_next = cms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cms_pkg::ST_CLEAR;
      row       <= '0;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      out_valid <= out_v_next;
      started   <= started_next;
    end
  end

  `CMS_ASSERT(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `CMS_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `CMS_ASSERT(a_fin_free, clk, rst, cmd.finish |-> !out_valid || out_ready,
              "result overwritten")
endmodule
`default_nettype wire

@@ hw/rtl/count_min_sketch_seed_param_core.sv @@
// ---------------------------------------------------------------------------
// count_min_sketch_seed_param_core
// Four-row count-min sketch producing a key seed parameter per request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries mode, four hash words, nonce and
//   batch_end. Output channel out_valid/out_ready returns seed_param,
//   min_count and solver_request, one result per item.
//   Configuration: cfg_we with cfg_index selects active_width, divisor,
//   blowup_disabled or solver_threshold; written while idle.
//   A key request runs, on one shared bit-serial divider, the four row modulo
//   steps, each followed by a counter read and update, then the divide of the
//   minimum and the nonce modulo, and last a finish step that raises out_valid.
//   in_ready rises together with out_valid; no item is taken while one is in work.
//   A clear item sweeps 4 row slots of MAX_WIDTH rounded up to a power of two
//   (16384 counters by default), one per cycle, then takes its finish step.
//   After reset the same sweep runs before in_ready rises.
//   The result register holds its item while out_ready is low; the next item
//   is still taken, and waits in its finish cycle until that transfer.
// ---------------------------------------------------------------------------
`default_nettype none
module count_min_sketch_seed_param_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [31:0] hash_word0,
  input  wire logic [31:0] hash_word1,
  input  wire logic [31:0] hash_word2,
  input  wire logic [31:0] hash_word3,
  input  wire logic [31:0] nonce,
  input  wire logic        batch_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      seed_param,
  output logic [31:0]      min_count,
  output logic             solver_request
);
  logic [12:0] active_width;
  logic [31:0] divisor;
  logic        blowup_disabled;
  logic [31:0] solver_threshold;
  cms_pkg::cmd_t  cmd;
  cms_pkg::stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_width     <= 13'd4096;
      divisor          <= 32'd1;
      blowup_disabled  <= 1'b0;
      solver_threshold <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cms_pkg::REG_WIDTH:   active_width     <= cfg_data[12:0];
        cms_pkg::REG_DIVISOR: divisor          <= cfg_data;
        cms_pkg::REG_BLOWUP:  blowup_disabled  <= cfg_data[0];
        cms_pkg::REG_THRESH:  solver_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  cms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .mode(mode),
    .stat(stat), .cmd(cmd)
  );

  cms_datapath #(.MAX_WIDTH(MAX_WIDTH), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .mode(mode),
    .hash_word0(hash_word0), .hash_word1(hash_word1), .hash_word2(hash_word2),
    .hash_word3(hash_word3), .nonce(nonce), .batch_end(batch_end),
    .active_width(active_width), .divisor(divisor),
    .blowup_disabled(blowup_disabled), .solver_threshold(solver_threshold),
    .seed_param(seed_param), .min_count(min_count),
    .solver_request(solver_request)
  );
endmodule
`default_nettype wire

@@ bench/tb_count_min_sketch_seed_param_core.sv @@
// ---------------------------------------------------------------------------
// tb_count_min_sketch_seed_param_core
// Self-checking bench: random and directed sketch requests, with an in-bench
// predictor of the four-row sketch, request counter and seed selection.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_count_min_sketch_seed_param_core;

  localparam int unsigned SK_WIDTH = 4096;
  localparam int unsigned CLR_CYCLES = 4 * SK_WIDTH;
  localparam int unsigned WATCHDOG_LIMIT = 4 * CLR_CYCLES + 2000;
  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] h0, h1, h2, h3;
    logic [31:0] nonce;
    logic        batch_end;
  } req_t;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] minc;
    logic        solver;
  } seed_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = cms_pkg::REG_WIDTH;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] seed_param, min_count;
  logic solver_request;

  always #5 clk = ~clk;

  count_min_sketch_seed_param_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(in_req.mode),
    .hash_word0(in_req.h0), .hash_word1(in_req.h1), .hash_word2(in_req.h2),
    .hash_word3(in_req.h3), .nonce(in_req.nonce), .batch_end(in_req.batch_end),
    .out_valid(out_valid), .out_ready(out_ready), .seed_param(seed_param),
    .min_count(min_count), .solver_request(solver_request)
  );

  // Predictor state
  logic [31:0] sketch [4*SK_WIDTH];
  logic [31:0] req_count;
  logic [12:0] cfg_width;
  logic [31:0] cfg_div;
  logic        cfg_blowup_off;
  logic [31:0] cfg_thresh;

  req_t      pending_reqs[$];
  seed_res_t expected_seeds[$];
  int unsigned errors = 0;
  bit quiet_mode = 0;       // no idling in the last part
  bit drain_hold = 0;       // sender pauses until results are back
  int unsigned long_hold = 0;
  int unsigned idle_cycles = 0;

  function automatic seed_res_t predict_seed(req_t r);
    seed_res_t res;
    logic [31:0] w, idx, c, minv, d, quot;
    logic [32:0] modulus;
    logic [31:0] hw [4];
    res = '0;
    if (r.mode == MODE_CLEAR) begin
      foreach (sketch[i]) sketch[i] = '0;
      req_count = '0;
      return res;
    end
    hw[0] = r.h0; hw[1] = r.h1; hw[2] = r.h2; hw[3] = r.h3;
    w = (cfg_width == 0) ? 1 : (cfg_width > SK_WIDTH ? SK_WIDTH : cfg_width);
    minv = '1;
    for (int k = 0; k < 4; k++) begin
      idx = k * SK_WIDTH + hw[k] % w;
      c = sketch[idx];
      if (c != '1) c = c + 1;
      sketch[idx] = c;
      if (c < minv) minv = c;
    end
    d = (cfg_div == 0) ? 1 : cfg_div;
    quot = minv / d;
    modulus = {1'b0, quot} + 33'd1;
    res.seed = 32'({1'b0, r.nonce} % modulus);
    if (cfg_blowup_off) res.seed = 32'd1;
    if (req_count != '1) req_count = req_count + 1;
    if (r.batch_end && req_count >= cfg_thresh) begin
      res.solver = 1'b1;
      req_count = '0;
    end
    res.minc = minv;
    return res;
  endfunction

  // Driver
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_seeds = {expected_seeds, predict_seed(in_req)};
        void'(pending_reqs.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the offered item
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 7);
        in_valid <= 1'b0;
      end else if (drain_hold || pending_reqs.size() <= (in_valid && in_ready ? 0 : 0)) begin
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_req <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls
  int unsigned out_gap = 0;
  seed_res_t exp_r;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_seeds.size() == 0) begin
          $display("%0t: unexpected result seed=%h min=%h req=%b", $time,
                   seed_param, min_count, solver_request);
          errors++;
        end else begin
          exp_r = expected_seeds.pop_front();
          if (seed_param !== exp_r.seed) begin
            $display("%0t: seed_param expected %h actual %h", $time, exp_r.seed, seed_param);
            errors++;
          end
          if (min_count !== exp_r.minc) begin
            $display("%0t: min_count expected %h actual %h", $time, exp_r.minc, min_count);
            errors++;
          end
          if (solver_request !== exp_r.solver) begin
            $display("%0t: solver_request expected %b actual %b", $time, exp_r.solver,
                     solver_request);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on accepted transfers
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("count_min_sketch_seed_param_core verification failed");
      $finish;
    end
  end

  task automatic add_req(logic m, logic [31:0] a, b, c, d, n, logic be);
    req_t r;
    r.mode = m; r.h0 = a; r.h1 = b; r.h2 = c; r.h3 = d; r.nonce = n; r.batch_end = be;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_seeds.size() > 0) @(posedge clk);
    // settle before the next configuration write
    repeat (CLR_CYCLES + 50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cms_pkg::REG_WIDTH:   cfg_width = val[12:0];
      cms_pkg::REG_DIVISOR: cfg_div = val;
      cms_pkg::REG_BLOWUP:  cfg_blowup_off = val[0];
      default:              cfg_thresh = val;
    endcase
  endtask

  // Random request, mostly key mode; small hash range so counters collide often
  task automatic add_random(int unsigned span);
    logic [31:0] h [4];
    for (int k = 0; k < 4; k++)
      h[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, span);
    add_req(($urandom_range(0, 60) == 0) ? MODE_CLEAR : MODE_KEY, h[0], h[1], h[2], h[3],
            $urandom, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    foreach (sketch[i]) sketch[i] = '0;
    req_count = '0;
    cfg_width = 13'd4096; cfg_div = 32'd1; cfg_blowup_off = 1'b0; cfg_thresh = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, clear, repeat hits, batch ends
    add_req(MODE_KEY, '0, '0, '0, '0, '0, 1'b0);
    add_req(MODE_KEY, '1, '1, '1, '1, '1, 1'b1);
    add_req(MODE_KEY, '0, '0, '0, '0, 32'h5555_5555, 1'b0);
    add_req(MODE_KEY, 32'd4096, 32'd8192, 32'd0, 32'd4096, 32'hAAAA_AAAA, 1'b1);
    add_req(MODE_CLEAR, '1, '1, '1, '1, '1, 1'b1);
    add_req(MODE_KEY, 32'd7, 32'd7, 32'd7, 32'd7, 32'd12345, 1'b0);
    wait_idle();

    // Narrow width, zero divisor, zero threshold
    write_reg(cms_pkg::REG_WIDTH, 32'd1);
    write_reg(cms_pkg::REG_DIVISOR, 32'd0);
    write_reg(cms_pkg::REG_THRESH, 32'd0);
    for (int i = 0; i < 8; i++) add_req(MODE_KEY, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, i[0]);
    wait_idle();
    write_reg(cms_pkg::REG_WIDTH, 32'h1FFF);
    write_reg(cms_pkg::REG_DIVISOR, 32'hFFFF_FFFF);
    write_reg(cms_pkg::REG_BLOWUP, 32'd1);
    write_reg(cms_pkg::REG_THRESH, 32'd3);
    for (int i = 0; i < 6; i++) add_req(MODE_KEY, 32'd5, 32'd5, 32'd5, 32'd5, $urandom, 1'b1);
    wait_idle();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cms_pkg::REG_WIDTH, (ph % 3 == 0) ? 32'd4096 : $urandom_range(1, 40));
      write_reg(cms_pkg::REG_DIVISOR, (ph == 2) ? 32'd1 : $urandom_range(1, 4));
      write_reg(cms_pkg::REG_BLOWUP, 32'(ph == 4));
      write_reg(cms_pkg::REG_THRESH, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(1, 10));
      for (int i = 0; i < 240; i++) add_random((ph % 3 == 0) ? 32'd10000 : 32'd60);
      if (ph == 1) begin
        // long enough for a second item to finish behind the held result
        long_hold = 1000;
        while (long_hold > 0) @(posedge clk);
      end
      if (ph == 3) begin
        while (pending_reqs.size() > 120) @(posedge clk);
        drain_hold = 1;
        while (expected_seeds.size() > 0 || in_valid) @(posedge clk);
        drain_hold = 0;
      end
      if (ph == 5) quiet_mode = 1;
      wait_idle();
    end

    if (errors == 0) $display("count_min_sketch_seed_param_core verification clean");
    else $display("count_min_sketch_seed_param_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire
